[hw/rtl/rrpg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrpg_pkg
// Shared constants, formats and helpers for the radial ripple pixel generator.
// ----------------------------------------------------------------------------
package rrpg_pkg;

   // field widths
   localparam int IN_W   = 10;
   localparam int TICK_W = 16;
   localparam int GREY_W = 8;

   localparam int IMAGE_SIDE_DEF = 1024;

   // phase in turns, Q0.40; constants are 2^40/(20*pi) and 2^40/(14*pi)
   localparam int PH_W   = 40;
   localparam int K_W    = 35;
   localparam int KSPLIT = 18;
   localparam logic [K_W-1:0] KD = 35'd17499271055;
   localparam logic [K_W-1:0] KT = 35'd24998958650;

   // cosine polynomial, Q30
   localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
   localparam logic [31:0] CA      = 32'd1324675879;
   localparam logic [31:0] CB      = 32'd272375560;
   localparam logic [31:0] CC      = 32'd22401992;
   localparam logic [31:0] CE      = 32'd987048;
   localparam int          Z_W     = 31;

   // cosine magnitude and quotient
   localparam int          MAG_W     = 16;
   localparam int          NUM_W     = 27;
   localparam int          Q_W       = 16;
   localparam logic [11:0] DIV_SCALE = 12'd2560;

   // grey = (128*2^15 +- 127*q) >> 15
   localparam logic [23:0] GREY_BIAS = 24'd4194304;
   localparam logic [6:0]  GREY_GAIN = 7'd127;

   // width of a signed center offset for a given image side
   function automatic int off_width(input int side);
      int w;
      w = $clog2(side);
      return ((w > IN_W) ? w : IN_W) + 1;
   endfunction

   // (p * z) >> 30, truncating
   function automatic logic [31:0] mul_q30(input logic [31:0] p, input logic [Z_W-1:0] z);
      logic [62:0] prod;
      prod = 63'(p) * 63'(z);
      return prod[61:30];
   endfunction

endpackage

[hw/rtl/rrpg_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrpg_req_if
// Pixel request channel: column, row and frame tick with valid/ready.
// ----------------------------------------------------------------------------
interface rrpg_req_if import rrpg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [IN_W-1:0]   pixel_col;
   logic [IN_W-1:0]   pixel_row;
   logic [TICK_W-1:0] frame_tick;

   modport source (output valid, output pixel_col, output pixel_row, output frame_tick,
                   input ready);
   modport sink   (input valid, input pixel_col, input pixel_row, input frame_tick,
                   output ready);
endinterface

[hw/rtl/rrpg_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrpg_rsp_if
// Grey level result channel with valid/ready.
// ----------------------------------------------------------------------------
interface rrpg_rsp_if import rrpg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [GREY_W-1:0] grey_level;

   modport source (output valid, output grey_level, input ready);
   modport sink   (input valid, input grey_level, output ready);
endinterface

[hw/rtl/radial_ripple_pixel_generator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_ripple_pixel_generator_top
// Per-pixel grey level of a damped radial ripple around the image center.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one pixel per beat (column, row, frame tick); rsp_chan
//   returns one grey level per beat, in request order. Both are valid/ready.
//   Throughput: one pixel per clock, sustained, for as long as rsp_chan
//   takes beats.
//   Stages: offsets, squares and radicand, then DIST_W = offset width + 8
//   square-root stages (one root bit per stage), then the phase multiply,
//   the quadrant fold, the square and the cosine polynomial (one multiply
//   per stage), then the numerator and divisor stage, a 16-stage divider
//   producing one quotient bit per stage and the grey level mapping.
//   Stall: the whole pipeline advances together; a skid register at the
//   output holds one finished beat while rsp_chan is stalled, so one more
//   request is still taken. With the skid full, req_chan.ready drops and
//   every stage holds.
//   Reset (synchronous): clears all valid bits and the skid; no state else.
// ----------------------------------------------------------------------------
module radial_ripple_pixel_generator_top import rrpg_pkg::*; #(
   parameter int IMAGE_SIDE = IMAGE_SIDE_DEF
) (
   input  logic       clock,
   input  logic       reset,
   rrpg_req_if.sink   req_chan,
   rrpg_rsp_if.source rsp_chan
);

   localparam int DIST_W = off_width(IMAGE_SIDE) + 8;

   logic              en;
   logic              dv, pv, gv;
   logic [DIST_W-1:0] d_dist, p_dist;
   logic [PH_W-1:0]   d_pb;
   logic [MAG_W-1:0]  p_mag;
   logic              p_neg;
   logic [GREY_W-1:0] g_grey;
   logic              skid_v_ff;
   logic [GREY_W-1:0] skid_grey_ff;

   // pipeline moves while the skid is empty
   assign en             = !skid_v_ff;
   assign req_chan.ready = en;

   rrpg_dist #(.IMAGE_SIDE(IMAGE_SIDE), .DIST_W(DIST_W)) u_dist (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (req_chan.valid),
      .pixel_col  (req_chan.pixel_col),
      .pixel_row  (req_chan.pixel_row),
      .frame_tick (req_chan.frame_tick),
      .out_valid  (dv),
      .out_dist   (d_dist),
      .out_pb     (d_pb)
   );

   rrpg_phase #(.DIST_W(DIST_W)) u_phase (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (dv),
      .in_dist   (d_dist),
      .in_pb     (d_pb),
      .out_valid (pv),
      .out_dist  (p_dist),
      .out_mag   (p_mag),
      .out_neg   (p_neg)
   );

   rrpg_div #(.DIST_W(DIST_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (pv),
      .in_dist   (p_dist),
      .in_mag    (p_mag),
      .in_neg    (p_neg),
      .out_valid (gv),
      .out_grey  (g_grey)
   );

   // skid: catch the last stage's beat when the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_v_ff <= 1'b0;
      end else if (en && gv && !rsp_chan.ready) begin
         skid_v_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         skid_v_ff <= 1'b0;
      end
      if (en && gv && !rsp_chan.ready) begin
         skid_grey_ff <= g_grey;
      end
   end

   assign rsp_chan.valid      = skid_v_ff | gv;
   assign rsp_chan.grey_level = skid_v_ff ? skid_grey_ff : g_grey;

   // assertions
   a_skid_hold: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff && !rsp_chan.ready |=> skid_v_ff && $stable(skid_grey_ff))
      else $error("skid beat lost or changed under stall");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(gv && !rsp_chan.ready))
      else $error("skid filled without a stalled beat");

   a_grey_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.grey_level != '0)
      else $error("grey level out of range");

endmodule

[hw/rtl/rrpg_dist.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrpg_dist
// Center offsets, squared radius and a one-bit-per-stage square root giving
// the Q.8 distance; the tick phase term rides along.
// ----------------------------------------------------------------------------
module rrpg_dist import rrpg_pkg::*; #(
   parameter int IMAGE_SIDE = IMAGE_SIDE_DEF,
   parameter int DIST_W     = off_width(IMAGE_SIDE) + 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [IN_W-1:0]   pixel_col,
   input  logic [IN_W-1:0]   pixel_row,
   input  logic [TICK_W-1:0] frame_tick,
   output logic              out_valid,
   output logic [DIST_W-1:0] out_dist,
   output logic [PH_W-1:0]   out_pb
);

   localparam int OW  = DIST_W - 8;
   localparam int RW  = 2 * DIST_W;
   localparam int RMW = DIST_W + 3;

   // front stages
   logic                     v0_ff, v1_ff, v2_ff;
   logic signed [OW-1:0]     ox_ff, oy_ff;
   logic [TICK_W+16:0]       pbh_ff;
   logic [TICK_W+17:0]       pbl_ff;
   logic [2*OW-1:0]          sqx_ff, sqy_ff;
   logic [PH_W-1:0]          pb1_ff, pb2_ff;
   logic [RW-1:0]            rad2_ff;
   logic signed [2*OW-1:0]   sqx_in, sqy_in;

   // root stages
   logic                     rv_ff   [DIST_W];
   logic [RW-1:0]            rad_ff  [DIST_W];
   logic [RMW-1:0]           rem_ff  [DIST_W];
   logic [DIST_W-1:0]        root_ff [DIST_W];
   logic [PH_W-1:0]          pbq_ff  [DIST_W];
   logic                     rv_in   [DIST_W];
   logic [RW-1:0]            rad_in  [DIST_W];
   logic [RMW-1:0]           rem_in  [DIST_W];
   logic [DIST_W-1:0]        root_in [DIST_W];
   logic [PH_W-1:0]          pbq_in  [DIST_W];

   assign sqx_in = ox_ff * ox_ff;
   assign sqy_in = oy_ff * oy_ff;

   // offsets, squares, radicand; tick term tick*KT mod 2^40
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
      if (en) begin
         ox_ff   <= OW'(pixel_col) - OW'(IMAGE_SIDE / 2);
         oy_ff   <= OW'(pixel_row) - OW'(IMAGE_SIDE / 2);
         pbh_ff  <= frame_tick * KT[K_W-1:KSPLIT];
         pbl_ff  <= frame_tick * KT[KSPLIT-1:0];
         sqx_ff  <= sqx_in;
         sqy_ff  <= sqy_in;
         pb1_ff  <= PH_W'({pbh_ff, {KSPLIT{1'b0}}}) + PH_W'(pbl_ff);
         rad2_ff <= {sqx_ff + sqy_ff, 16'b0};
         pb2_ff  <= pb1_ff;
      end
   end

   // one root bit per stage, restoring form
   always_comb begin
      logic [RW-1:0]     rp;
      logic [RMW-1:0]    remp, rs, tr;
      logic [DIST_W-1:0] rtp;
      for (int k = 0; k < DIST_W; k++) begin
         if (k == 0) begin
            rv_in[k]  = v2_ff;
            rp        = rad2_ff;
            remp      = '0;
            rtp       = '0;
            pbq_in[k] = pb2_ff;
         end else begin
            rv_in[k]  = rv_ff[k-1];
            rp        = rad_ff[k-1];
            remp      = rem_ff[k-1];
            rtp       = root_ff[k-1];
            pbq_in[k] = pbq_ff[k-1];
         end
         rs        = {remp[RMW-3:0], rp[RW-1 -: 2]};
         tr        = RMW'({rtp, 2'b01});
         rad_in[k] = rp << 2;
         if (rs >= tr) begin
            rem_in[k]  = rs - tr;
            root_in[k] = {rtp[DIST_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = rs;
            root_in[k] = {rtp[DIST_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DIST_W; k++) begin
         if (reset) begin
            rv_ff[k] <= 1'b0;
         end else if (en) begin
            rv_ff[k] <= rv_in[k];
         end
         if (en) begin
            rad_ff[k]  <= rad_in[k];
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            pbq_ff[k]  <= pbq_in[k];
         end
      end
   end

   assign out_valid = rv_ff[DIST_W-1];
   assign out_dist  = root_ff[DIST_W-1];
   assign out_pb    = pbq_ff[DIST_W-1];

endmodule

[hw/rtl/rrpg_phase.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrpg_phase
// Ripple phase from distance and tick, quadrant fold and the cosine
// polynomial in Q30, one multiply per stage; yields a Q1.15 magnitude + sign.
// ----------------------------------------------------------------------------
module rrpg_phase import rrpg_pkg::*; #(
   parameter int DIST_W = off_width(IMAGE_SIDE_DEF) + 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [DIST_W-1:0] in_dist,
   input  logic [PH_W-1:0]   in_pb,
   output logic              out_valid,
   output logic [DIST_W-1:0] out_dist,
   output logic [MAG_W-1:0]  out_mag,
   output logic              out_neg
);

   localparam int NST = 8;

   logic                      v_ff    [NST];
   logic [DIST_W-1:0]         dist_ff [NST];
   logic                      neg_ff  [1:NST-1];
   logic [DIST_W+K_W-KSPLIT-1:0] mhi_ff;
   logic [DIST_W+KSPLIT-1:0]  mlo_ff;
   logic [PH_W-1:0]           pb_ff;
   logic [14:0]               xp_ff;
   logic [Z_W-1:0]            z_ff    [2:NST-3];
   logic [31:0]               p4_ff, p5_ff, p6_ff, t_ff;
   logic [MAG_W-1:0]          mag_ff;

   logic [47:0]               full_in;
   logic [PH_W-1:0]           diff_in;
   logic [15:0]               ph_in;
   logic [29:0]               xx_in;
   logic [31:0]               pc_in;
   logic [30:0]               rnd_in;

   // phase Q0.40 = (d*KD >> 8) - tick*KT, keep top 16 bits
   assign full_in = 48'({mhi_ff, {KSPLIT{1'b0}}}) + 48'(mlo_ff);
   assign diff_in = full_in[47:8] - pb_ff;
   assign ph_in   = diff_in[PH_W-1 -: 16];
   assign xx_in   = 30'(xp_ff) * 30'(xp_ff);
   assign pc_in   = (t_ff >= ONE_Q30) ? 32'd0 : (ONE_Q30 - t_ff);
   assign rnd_in  = pc_in[30:0] + 31'd16384;

   // valid chain and distance
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
      if (en) begin
         dist_ff[0] <= in_dist;
      end
      for (int k = 1; k < NST; k++) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_ff[k-1];
         end
         if (en) begin
            dist_ff[k] <= dist_ff[k-1];
         end
      end
   end

   // arithmetic stages
   always_ff @(posedge clock) begin
      if (en) begin
         mhi_ff    <= in_dist * KD[K_W-1:KSPLIT];
         mlo_ff    <= in_dist * KD[KSPLIT-1:0];
         pb_ff     <= in_pb;
         // fold into first quadrant; quadrants 1 and 2 are negative
         xp_ff     <= ph_in[14] ? (15'd16384 - {1'b0, ph_in[13:0]}) : {1'b0, ph_in[13:0]};
         neg_ff[1] <= ph_in[15] ^ ph_in[14];
         neg_ff[2] <= neg_ff[1];
         z_ff[2]   <= {xx_in[28:0], 2'b00};
         p4_ff     <= CC - mul_q30(CE, z_ff[2]);
         p5_ff     <= CB - mul_q30(p4_ff, z_ff[3]);
         p6_ff     <= CA - mul_q30(p5_ff, z_ff[4]);
         t_ff      <= mul_q30(p6_ff, z_ff[5]);
         mag_ff    <= rnd_in[30:15];
         // sign and z ride along with the polynomial
         for (int k = 3; k < NST; k++) begin
            neg_ff[k] <= neg_ff[k-1];
         end
         for (int k = 3; k < NST-2; k++) begin
            z_ff[k] <= z_ff[k-1];
         end
      end
   end

   assign out_valid = v_ff[NST-1];
   assign out_dist  = dist_ff[NST-1];
   assign out_mag   = mag_ff;
   assign out_neg   = neg_ff[NST-1];

endmodule

[hw/rtl/rrpg_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrpg_div
// Damping quotient cos*2560/(d+2560), one quotient bit per stage, then the
// grey level mapping.
// ----------------------------------------------------------------------------
module rrpg_div import rrpg_pkg::*; #(
   parameter int DIST_W = off_width(IMAGE_SIDE_DEF) + 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [DIST_W-1:0] in_dist,
   input  logic [MAG_W-1:0]  in_mag,
   input  logic              in_neg,
   output logic              out_valid,
   output logic [GREY_W-1:0] out_grey
);

   localparam int DV_W = DIST_W + 1;
   localparam int CW   = NUM_W + DV_W;

   logic              v0_ff, vg_ff;
   logic [NUM_W-1:0]  num_ff;
   logic [DV_W-1:0]   dv0_ff;
   logic              neg0_ff;
   logic [GREY_W-1:0] grey_ff;

   logic              v_ff   [Q_W];
   logic [NUM_W-1:0]  rem_ff [Q_W];
   logic [DV_W-1:0]   dv_ff  [Q_W];
   logic [Q_W-1:0]    q_ff   [Q_W];
   logic              neg_ff [Q_W];
   logic              v_in   [Q_W];
   logic [NUM_W-1:0]  rem_in [Q_W];
   logic [DV_W-1:0]   dv_in  [Q_W];
   logic [Q_W-1:0]    q_in   [Q_W];
   logic              neg_in [Q_W];

   logic [22:0]       prod_in;
   logic [23:0]       g_in;

   // numerator and divisor
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= in_valid;
      end
      if (en) begin
         num_ff  <= NUM_W'(in_mag) * NUM_W'(DIV_SCALE);
         dv0_ff  <= DV_W'(in_dist) + DV_W'(DIV_SCALE);
         neg0_ff <= in_neg;
      end
   end

   // restoring divide, quotient MSB first; quotient never exceeds 16 bits
   always_comb begin
      logic [NUM_W-1:0] rp;
      logic [DV_W-1:0]  dp;
      logic [Q_W-1:0]   qp;
      logic [CW-1:0]    sh, dd;
      for (int k = 0; k < Q_W; k++) begin
         if (k == 0) begin
            v_in[k]   = v0_ff;
            rp        = num_ff;
            dp        = dv0_ff;
            qp        = '0;
            neg_in[k] = neg0_ff;
         end else begin
            v_in[k]   = v_ff[k-1];
            rp        = rem_ff[k-1];
            dp        = dv_ff[k-1];
            qp        = q_ff[k-1];
            neg_in[k] = neg_ff[k-1];
         end
         sh       = CW'(rp) >> (Q_W - 1 - k);
         dd       = CW'(dp) << (Q_W - 1 - k);
         dv_in[k] = dp;
         if (sh >= CW'(dp)) begin
            rem_in[k] = rp - NUM_W'(dd);
            q_in[k]   = {qp[Q_W-2:0], 1'b1};
         end else begin
            rem_in[k] = rp;
            q_in[k]   = {qp[Q_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < Q_W; k++) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_in[k];
         end
         if (en) begin
            rem_ff[k] <= rem_in[k];
            dv_ff[k]  <= dv_in[k];
            q_ff[k]   <= q_in[k];
            neg_ff[k] <= neg_in[k];
         end
      end
   end

   // grey = (bias +- 127*q) >> 15; always within 1..255
   assign prod_in = 23'(q_ff[Q_W-1]) * 23'(GREY_GAIN);
   assign g_in    = neg_ff[Q_W-1] ? (GREY_BIAS - 24'(prod_in)) : (GREY_BIAS + 24'(prod_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         vg_ff <= 1'b0;
      end else if (en) begin
         vg_ff <= v_ff[Q_W-1];
      end
      if (en) begin
         grey_ff <= g_in[22:15];
      end
   end

   assign out_valid = vg_ff;
   assign out_grey  = grey_ff;

endmodule
